### rtl/grc_pkg.sv
package grc_pkg;

    localparam int MAP_SIZE           = 32;
    localparam int MAP_W              = 5;
    localparam int MAP_DEPTH          = MAP_SIZE * MAP_SIZE;
    localparam int ADDR_W             = 2 * MAP_W;
    localparam int SCREEN_WIDTH       = 128;
    localparam int SCREEN_HEIGHT      = 112;
    localparam int TEXTURE_WIDTH      = 32;
    localparam int WIDE_TEXTURE_WIDTH = 128;

    localparam int COL_W  = 7;
    localparam int CELL_W = 4;
    localparam int POS_W  = 21;
    localparam int VEC_W  = 16;
    localparam int RAY_W  = 18;
    localparam int AD_W   = 17;
    localparam int DIST_W = 23;
    localparam int PERP_W = 24;
    localparam int LH_W   = 16;
    localparam int ROW_W  = 7;
    localparam int NUM_W  = 37;
    localparam int DEN_W  = 24;
    localparam int CNT_W  = 6;
    localparam int PROD_W = 40;
    localparam int IDX_W  = 3;

    localparam logic [PERP_W-1:0] PERP_MAX   = 24'hFFFFFF;
    localparam logic [LH_W-1:0]   LH_MAX     = 16'hFFFF;
    localparam logic [CELL_W-1:0] WIDE_CELL  = 4'd8;
    localparam logic [ROW_W-1:0]  HALF_ROWS  = 7'(SCREEN_HEIGHT / 2);
    localparam logic [ROW_W-1:0]  LAST_ROW   = 7'(SCREEN_HEIGHT - 1);
    localparam logic [NUM_W-1:0]  HEIGHT_NUM = 37'(SCREEN_HEIGHT) << 16;

    localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_MIRROR  = 3'd6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [VEC_W-1:0] dir_x;
        logic [VEC_W-1:0] dir_y;
        logic [VEC_W-1:0] plane_x;
        logic [VEC_W-1:0] plane_y;
        logic             mirror;
    } cam_cfg_t;

    typedef struct packed {
        logic              command;
        logic [MAP_W-1:0]  cell_x;
        logic [MAP_W-1:0]  cell_y;
        logic [CELL_W-1:0] cell_value;
        logic [COL_W-1:0]  screen_column;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]  texture_column;
        logic [ROW_W-1:0]  span_end;
        logic [ROW_W-1:0]  span_start;
        logic [LH_W-1:0]   line_height;
        logic [PERP_W-1:0] perp_distance;
        logic              hit_side;
        logic [CELL_W-1:0] wall_cell;
        logic [COL_W-1:0]  out_column;
        logic              wall_hit;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAY_X,
        ST_RAY_Y,
        ST_INIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_STEP,
        ST_CHECK,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_TEX,
        ST_HGT_GO,
        ST_HGT_WAIT,
        ST_OUT
    } state_t;

endpackage

### rtl/grc_map_ram.sv
module grc_map_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [grc_pkg::ADDR_W-1:0] waddr,
    input  logic [grc_pkg::CELL_W-1:0] wdata,
    input  logic [grc_pkg::ADDR_W-1:0] raddr,
    output logic [grc_pkg::CELL_W-1:0] rdata
);
    import grc_pkg::*;

    logic [CELL_W-1:0] mem [0:MAP_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/grc_divider.sv
module grc_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [grc_pkg::NUM_W-1:0] num,
    input  logic [grc_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [grc_pkg::NUM_W-1:0] quot
);
    import grc_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = den;
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### rtl/grc_core.sv
module grc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  grc_pkg::cam_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  grc_pkg::item_t    item,
    output logic              res_valid,
    input  logic              res_ready,
    output grc_pkg::result_t  res
);
    import grc_pkg::*;

    state_t state_reg, state_next;

    logic [COL_W-1:0]        col_reg, col_next;
    logic signed [VEC_W-1:0] cx_reg, cx_next;
    logic [RAY_W-1:0]        dx_reg, dx_next;
    logic [RAY_W-1:0]        dy_reg, dy_next;
    logic [AD_W-1:0]         adx_reg, adx_next;
    logic [AD_W-1:0]         ady_reg, ady_next;
    logic [DIST_W-1:0]       nx_reg, nx_next;
    logic [DIST_W-1:0]       ny_reg, ny_next;
    logic [DIST_W-1:0]       prev_reg, prev_next;
    logic [MAP_W:0]          mx_reg, mx_next;
    logic [MAP_W:0]          my_reg, my_next;
    logic                    side_reg, side_next;
    logic                    off_reg, off_next;
    logic                    hit_reg, hit_next;
    logic [PROD_W-1:0]       pa_reg, pa_next;
    logic [PROD_W-1:0]       pb_reg, pb_next;
    logic [CELL_W-1:0]       cell_reg, cell_next;
    logic [NUM_W-1:0]        q_reg, q_next;
    logic [15:0]             frac_reg, frac_next;
    logic [LH_W-1:0]         lh_reg, lh_next;

    logic signed [30:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [49:0] mul_p;

    logic [9:0]        col_off;
    logic [RAY_W-1:0]  neg_dx, neg_dy;
    logic              take_x;
    logic [AD_W-1:0]   ad_sel;
    logic              rd_nonzero;
    logic [CELL_W-1:0] rd_data;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quot;
    logic [DEN_W-1:0]  div_den;
    logic [PERP_W-1:0] perp;
    logic [14:0]       half_h;
    logic [COL_W-1:0]  tex_raw, tex_w1;
    logic              tex_flip;

    assign mul_p = mul_a * mul_b;

    assign col_off    = {2'b00, item.screen_column, 1'b0} - 10'(SCREEN_WIDTH);
    assign neg_dx     = -dx_reg;
    assign neg_dy     = -dy_reg;
    assign take_x     = pa_reg < pb_reg;
    assign ad_sel     = side_reg ? ady_reg : adx_reg;
    assign rd_nonzero = rd_data != '0;
    assign perp       = (q_reg[NUM_W-1:PERP_W] != '0) ? PERP_MAX : q_reg[PERP_W-1:0];

    grc_map_ram u_map (
        .clk   (clk),
        .we    (in_valid && in_ready && item.command == CMD_WRITE),
        .waddr ({item.cell_x, item.cell_y}),
        .wdata (item.cell_value),
        .raddr ({mx_next[MAP_W-1:0], my_next[MAP_W-1:0]}),
        .rdata (rd_data)
    );

    grc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && item.command == CMD_CAST)
                begin
                    state_next = ST_RAY_X;
                end
            end
            ST_RAY_X:     state_next = ST_RAY_Y;
            ST_RAY_Y:     state_next = ST_INIT;
            ST_INIT:      state_next = ST_MUL_A;
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_STEP;
            ST_STEP:      state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (off_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (rd_nonzero)
                begin
                    state_next = (ad_sel == '0) ? ST_TEX : ST_DIST_GO;
                end
                else
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_DIST_GO:   state_next = ST_DIST_WAIT;
            ST_DIST_WAIT: state_next = div_done ? ST_TEX : ST_DIST_WAIT;
            ST_TEX:       state_next = (q_reg == '0) ? ST_OUT : ST_HGT_GO;
            ST_HGT_GO:    state_next = ST_HGT_WAIT;
            ST_HGT_WAIT:  state_next = div_done ? ST_OUT : ST_HGT_WAIT;
            ST_OUT:       state_next = res_ready ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        col_next  = col_reg;
        cx_next   = cx_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        adx_next  = adx_reg;
        ady_next  = ady_reg;
        nx_next   = nx_reg;
        ny_next   = ny_reg;
        prev_next = prev_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        side_next = side_reg;
        off_next  = off_reg;
        hit_next  = hit_reg;
        pa_next   = pa_reg;
        pb_next   = pb_reg;
        cell_next = cell_reg;
        q_next    = q_reg;
        frac_next = frac_reg;
        lh_next   = lh_reg;
        mul_a     = {{15{cx_reg[VEC_W-1]}}, cx_reg};
        mul_b     = {{3{cfg.plane_x[VEC_W-1]}}, cfg.plane_x};
        div_start = 1'b0;
        div_num   = {prev_reg, 14'b0};
        div_den   = {7'b0, ad_sel};
        in_ready  = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && item.command == CMD_CAST)
                begin
                    col_next = item.screen_column;
                    cx_next  = {col_off[8:0], 7'b0};
                    hit_next = 1'b0;
                end
            end
            ST_RAY_X:
            begin
                dx_next = {{2{cfg.dir_x[VEC_W-1]}}, cfg.dir_x} + {mul_p[30], mul_p[30:14]};
            end
            ST_RAY_Y:
            begin
                mul_b   = {{3{cfg.plane_y[VEC_W-1]}}, cfg.plane_y};
                dy_next = {{2{cfg.dir_y[VEC_W-1]}}, cfg.dir_y} + {mul_p[30], mul_p[30:14]};
            end
            ST_INIT:
            begin
                adx_next = dx_reg[RAY_W-1] ? neg_dx[AD_W-1:0] : dx_reg[AD_W-1:0];
                ady_next = dy_reg[RAY_W-1] ? neg_dy[AD_W-1:0] : dy_reg[AD_W-1:0];
                nx_next  = dx_reg[RAY_W-1] ? {7'b0, cfg.pos_x[15:0]}
                                           : 23'(17'h10000 - {1'b0, cfg.pos_x[15:0]});
                ny_next  = dy_reg[RAY_W-1] ? {7'b0, cfg.pos_y[15:0]}
                                           : 23'(17'h10000 - {1'b0, cfg.pos_y[15:0]});
                mx_next  = {1'b0, cfg.pos_x[POS_W-1:16]};
                my_next  = {1'b0, cfg.pos_y[POS_W-1:16]};
                side_next = 1'b0;
            end
            ST_MUL_A:
            begin
                mul_a   = {8'b0, nx_reg};
                mul_b   = {2'b0, ady_reg};
                pa_next = mul_p[PROD_W-1:0];
            end
            ST_MUL_B:
            begin
                mul_a   = {8'b0, ny_reg};
                mul_b   = {2'b0, adx_reg};
                pb_next = mul_p[PROD_W-1:0];
            end
            ST_STEP:
            begin
                if (take_x)
                begin
                    prev_next = nx_reg;
                    nx_next   = nx_reg + 23'h10000;
                    mx_next   = mx_reg + (dx_reg[RAY_W-1] ? '1 : 6'd1);
                    side_next = 1'b0;
                end
                else
                begin
                    prev_next = ny_reg;
                    ny_next   = ny_reg + 23'h10000;
                    my_next   = my_reg + (dy_reg[RAY_W-1] ? '1 : 6'd1);
                    side_next = 1'b1;
                end
                off_next = mx_next[MAP_W] | my_next[MAP_W];
            end
            ST_CHECK:
            begin
                if (!off_reg && rd_nonzero)
                begin
                    hit_next  = 1'b1;
                    cell_next = rd_data;
                    q_next    = {13'b0, PERP_MAX};
                end
            end
            ST_DIST_GO:
            begin
                div_start = 1'b1;
            end
            ST_DIST_WAIT:
            begin
                if (div_done)
                begin
                    q_next = div_quot;
                end
            end
            ST_TEX:
            begin
                mul_a     = {1'b0, q_reg[29:0]};
                mul_b     = side_reg ? {dx_reg[RAY_W-1], dx_reg} : {dy_reg[RAY_W-1], dy_reg};
                frac_next = (side_reg ? cfg.pos_x[15:0] : cfg.pos_y[15:0]) + mul_p[29:14];
                lh_next   = LH_MAX;
            end
            ST_HGT_GO:
            begin
                div_start = 1'b1;
                div_num   = HEIGHT_NUM;
                div_den   = perp;
            end
            ST_HGT_WAIT:
            begin
                if (div_done)
                begin
                    lh_next = (div_quot[NUM_W-1:LH_W] != '0) ? LH_MAX : div_quot[LH_W-1:0];
                end
            end
            ST_OUT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign half_h   = lh_reg[LH_W-1:1];
    assign tex_raw  = (cell_reg == WIDE_CELL) ? frac_reg[15:9] : {2'b00, frac_reg[15:11]};
    assign tex_w1   = (cell_reg == WIDE_CELL) ? 7'(WIDE_TEXTURE_WIDTH - 1)
                                              : 7'(TEXTURE_WIDTH - 1);
    assign tex_flip = side_reg ? dy_reg[RAY_W-1] : (!dx_reg[RAY_W-1] && dx_reg != '0);

    always_comb
    begin
        res.out_column = cfg.mirror ? 7'(SCREEN_WIDTH - 1) - col_reg : col_reg;
        res.wall_hit   = hit_reg;
        if (hit_reg)
        begin
            res.wall_cell      = cell_reg;
            res.hit_side       = side_reg;
            res.perp_distance  = perp;
            res.line_height    = lh_reg;
            res.span_start     = (half_h >= 15'(HALF_ROWS)) ? '0 : HALF_ROWS - half_h[ROW_W-1:0];
            res.span_end       = (half_h >= 15'(LAST_ROW - HALF_ROWS)) ? LAST_ROW
                                                       : HALF_ROWS + half_h[ROW_W-1:0];
            res.texture_column = tex_flip ? tex_w1 - tex_raw : tex_raw;
        end
        else
        begin
            res.wall_cell      = '0;
            res.hit_side       = 1'b0;
            res.perp_distance  = PERP_MAX;
            res.line_height    = '0;
            res.span_start     = HALF_ROWS;
            res.span_end       = HALF_ROWS;
            res.texture_column = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        cx_reg   <= cx_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        prev_reg <= prev_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        side_reg <= side_next;
        off_reg  <= off_next;
        hit_reg  <= hit_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        cell_reg <= cell_next;
        q_reg    <= q_next;
        frac_reg <= frac_next;
        lh_reg   <= lh_next;
    end

endmodule

### rtl/grid_raycast_column.sv
// A cell-write word is taken while idle and makes no result; one word is in work at a time.
// A cast word runs RAY_X, RAY_Y and INIT, then MUL_A, MUL_B, STEP and CHECK per DDA grid cell.
// A wall hit adds serial divisions for distance and line height around TEX, each skipped on a
// zero divisor; a ray that leaves the map goes from CHECK to OUT; a full output register waits.
// Reset loads the camera registers with their defaults and empties the output register.
// Map cells have no reset and must be written before a cast reads them.
module grid_raycast_column (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // cell_x, cell_y, cell_value, screen_column
    input  logic                       s_tuser,   // command
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [79:0]                m_tdata,   // out_column, wall_cell, hit_side,
                                                  // perp_distance, line_height, span_start,
                                                  // span_end, texture_column
    output logic                       m_tuser,   // wall_hit
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [grc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [grc_pkg::POS_W-1:0]  cfg_data
);
    import grc_pkg::*;

    cam_cfg_t cfg_reg, cfg_next;
    item_t    item;
    result_t  res;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     res_valid, res_ready;

    assign item.command       = s_tuser;
    assign item.cell_x        = s_tdata[4:0];
    assign item.cell_y        = s_tdata[9:5];
    assign item.cell_value    = s_tdata[13:10];
    assign item.screen_column = s_tdata[20:14];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_POS_X:   cfg_next.pos_x   = cfg_data;
                REG_POS_Y:   cfg_next.pos_y   = cfg_data;
                REG_DIR_X:   cfg_next.dir_x   = cfg_data[VEC_W-1:0];
                REG_DIR_Y:   cfg_next.dir_y   = cfg_data[VEC_W-1:0];
                REG_PLANE_X: cfg_next.plane_x = cfg_data[VEC_W-1:0];
                REG_PLANE_Y: cfg_next.plane_y = cfg_data[VEC_W-1:0];
                REG_MIRROR:  cfg_next.mirror  = cfg_data[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x   <= 21'h160000;
            cfg_reg.pos_y   <= 21'h0B8000;
            cfg_reg.dir_x   <= 16'hC000;
            cfg_reg.dir_y   <= 16'h0000;
            cfg_reg.plane_x <= 16'h0000;
            cfg_reg.plane_y <= 16'h2A3D;
            cfg_reg.mirror  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    grc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.wall_hit;
    assign m_tdata  = {7'b0, out_reg.texture_column, out_reg.span_end, out_reg.span_start,
                       out_reg.line_height, out_reg.perp_distance, out_reg.hit_side,
                       out_reg.wall_cell, out_reg.out_column};

endmodule

### rtl/grc_checker.sv
module grc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser
);
    import grc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_WRITE && !m_tvalid |=> !m_tvalid)
        else $error("cell write produced a result");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_CAST |=> !s_tready)
        else $error("input taken while a cast is in work");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[35:12] == PERP_MAX && m_tdata[51:36] == '0)
        else $error("miss result without saturated distance");

endmodule

bind grid_raycast_column grc_checker u_grc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
